@@ rtl/core/mfek_pkg.sv @@
// Package: shared constants, types and encodings for the max-flow engine.
package mfek_pkg;

	localparam int NODES     = 16;
	localparam int NODE_W    = 4;
	localparam int CELL_W    = 2 * NODE_W;
	localparam int CAP_W     = 16;
	localparam int RES_W     = CAP_W + 1;
	localparam int FLOW_W    = 20;
	localparam int QCNT_W    = NODE_W + 1;

	localparam logic [RES_W-1:0] INF_NECK = {RES_W{1'b1}};

	// Configuration register indexes
	localparam logic REG_SOURCE = 1'b0;
	localparam logic REG_SINK   = 1'b1;

	// Input action codes
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_COPY,
		ST_BFS_INIT,
		ST_POP,
		ST_SCAN_RD,
		ST_SCAN,
		ST_AUG_RD_FWD,
		ST_AUG_WR_FWD,
		ST_AUG_WR_REV,
		ST_AUG_ADV,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear_step;
		logic copy_step;
		logic flow_clear;
		logic bfs_init;
		logic pop;
		logic scan_rd;
		logic scan_eval;
		logic aug_init;
		logic aug_rd_fwd;
		logic aug_wr_fwd;
		logic aug_wr_rev;
		logic load_wr;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic copy_last;
		logic queue_empty;
		logic scan_last;
		logic found;
		logic aug_at_src;
	} stat_t;

endpackage

@@ rtl/core/mfek_datapath.sv @@
// Datapath: capacity and residual memories, search queue, parent table, flow total.
module mfek_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mfek_pkg::cmd_t               cmd,
	output mfek_pkg::stat_t              stat,
	input  logic [mfek_pkg::NODE_W-1:0]  src,
	input  logic [mfek_pkg::NODE_W-1:0]  dst,
	input  logic [mfek_pkg::NODE_W-1:0]  ld_from,
	input  logic [mfek_pkg::NODE_W-1:0]  ld_to,
	input  logic [mfek_pkg::CAP_W-1:0]   ld_cap,
	output logic [mfek_pkg::FLOW_W-1:0]  flow
);
	import mfek_pkg::*;

	logic [CAP_W-1:0]  cap_mem [NODES*NODES];
	logic [RES_W-1:0]  res_mem [NODES*NODES];
	logic [CAP_W-1:0]  cap_rd_q;
	logic [RES_W-1:0]  res_rd_q;

	logic [CELL_W:0]   sweep_q;
	logic [CELL_W-1:0] copy_addr_q;
	logic              copy_vld_q;

	logic [NODE_W-1:0] q_node_q [NODES];
	logic [RES_W-1:0]  q_neck_q [NODES];
	logic [QCNT_W-1:0] head_q, tail_q;
	logic [NODES-1:0]  seen_q;
	logic [NODE_W-1:0] parent_q [NODES];
	logic [NODE_W-1:0] u_q, n_q, v_q, p_q;
	logic [RES_W-1:0]  neck_q, path_q;
	logic [FLOW_W-1:0] flow_q;

	logic [CELL_W-1:0] cap_raddr, res_raddr, res_waddr;
	logic [RES_W-1:0]  res_wdata;
	logic              res_we;
	logic [RES_W-1:0]  m;

	// Sweep counter for clear and copy passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.clear_step || cmd.copy_step) begin
			sweep_q <= (sweep_q[CELL_W]) ? '0 : sweep_q + 1'b1;
		end else begin
			sweep_q <= '0;
		end
	end

	assign stat.clear_last = sweep_q == (CELL_W+1)'(NODES*NODES - 1);
	assign stat.copy_last  = sweep_q[CELL_W];

	// Capacity memory: load writes, clear sweep, copy reads
	assign cap_raddr = sweep_q[CELL_W-1:0];
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			cap_mem[sweep_q[CELL_W-1:0]] <= '0;
		end else if (cmd.load_wr) begin
			cap_mem[{ld_from, ld_to}] <= ld_cap;
		end
		cap_rd_q <= cap_mem[cap_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_vld_q <= 1'b0;
		end else begin
			copy_vld_q <= cmd.copy_step && !sweep_q[CELL_W];
		end
	end
	always_ff @(posedge clk) begin
		copy_addr_q <= sweep_q[CELL_W-1:0];
	end

	// Residual memory port mux
	always_comb begin
		res_we    = 1'b0;
		res_waddr = copy_addr_q;
		res_wdata = {1'b0, cap_rd_q};
		res_raddr = {u_q, n_q};
		if (copy_vld_q) begin
			res_we = 1'b1;
		end else if (cmd.aug_wr_fwd) begin
			res_we    = 1'b1;
			res_waddr = {p_q, v_q};
			res_wdata = res_rd_q - path_q;
		end else if (cmd.aug_wr_rev) begin
			res_we    = 1'b1;
			res_waddr = {v_q, p_q};
			res_wdata = res_rd_q + path_q;
		end
		if (cmd.aug_rd_fwd) res_raddr = {p_q, v_q};
		else if (cmd.aug_wr_fwd) res_raddr = {v_q, p_q};
	end

	always_ff @(posedge clk) begin
		if (res_we) res_mem[res_waddr] <= res_wdata;
		res_rd_q <= res_mem[res_raddr];
	end

	// Search and augmentation control registers
	assign m = (res_rd_q < neck_q) ? res_rd_q : neck_q;
	assign stat.queue_empty = head_q == tail_q;
	assign stat.scan_last   = n_q == NODE_W'(NODES - 1);
	assign stat.found       = (n_q != u_q) && !seen_q[n_q] && (res_rd_q != '0) && (n_q == dst);
	assign stat.aug_at_src  = v_q == src;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			seen_q <= '0;
			flow_q <= '0;
		end else begin
			if (cmd.flow_clear) flow_q <= '0;
			if (cmd.bfs_init) begin
				head_q <= '0;
				tail_q <= QCNT_W'(1);
				seen_q <= NODES'(1) << src;
			end
			if (cmd.pop) head_q <= head_q + 1'b1;
			if (cmd.scan_eval && (n_q != u_q) && !seen_q[n_q] && (res_rd_q != '0)) begin
				seen_q[n_q] <= 1'b1;
				if (n_q != dst && tail_q != QCNT_W'(NODES)) tail_q <= tail_q + 1'b1;
			end
			if (cmd.aug_init) flow_q <= flow_q + FLOW_W'(path_q);
		end
	end

	// Payload registers: queue, parents, cursors
	always_ff @(posedge clk) begin
		if (cmd.bfs_init) begin
			q_node_q[0] <= src;
			q_neck_q[0] <= INF_NECK;
		end
		if (cmd.pop) begin
			u_q    <= q_node_q[head_q[NODE_W-1:0]];
			neck_q <= q_neck_q[head_q[NODE_W-1:0]];
			n_q    <= '0;
		end
		if (cmd.scan_eval) begin
			if ((n_q != u_q) && !seen_q[n_q] && (res_rd_q != '0)) begin
				parent_q[n_q] <= u_q;
				path_q <= m;
				if (n_q != dst && tail_q != QCNT_W'(NODES)) begin
					q_node_q[tail_q[NODE_W-1:0]] <= n_q;
					q_neck_q[tail_q[NODE_W-1:0]] <= m;
				end
			end
			n_q <= n_q + 1'b1;
		end
		if (cmd.aug_init) begin
			v_q <= dst;
			p_q <= parent_q[dst];
		end
		if (cmd.aug_wr_rev) begin
			v_q <= p_q;
			p_q <= parent_q[p_q];
		end
	end

	assign flow = flow_q;

`ifndef NO_ASSERTIONS
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= QCNT_W'(NODES)) else $error("queue tail overrun");
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("queue head passed tail");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({copy_vld_q, cmd.aug_wr_fwd, cmd.aug_wr_rev}))
		else $error("residual write conflict");
`endif

endmodule

@@ rtl/core/mfek_ctrl.sv @@
// Controller: state machine sequencing clear, load, copy, searches and augmentation.
module mfek_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_fire,
	input  logic                        in_action,
	input  logic                        in_edge_ok,
	input  logic                        out_ready,
	input  logic                        bad_cfg,
	input  mfek_pkg::stat_t             stat,
	output mfek_pkg::cmd_t              cmd,
	output logic                        in_ready,
	output logic                        out_valid
);
	import mfek_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

	// Next state and command decode
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					if (in_action == ACT_LOAD) begin
						cmd.load_wr = in_edge_ok;
					end else begin
						cmd.flow_clear = 1'b1;
						state_d = ST_COPY;
					end
				end
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (stat.copy_last) state_d = bad_cfg ? ST_DONE : ST_BFS_INIT;
			end
			ST_BFS_INIT: begin
				cmd.bfs_init = 1'b1;
				state_d = ST_POP;
			end
			ST_POP: begin
				if (stat.queue_empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.pop = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_eval = 1'b1;
				if (stat.found) state_d = ST_AUG_RD_FWD;
				else if (stat.scan_last) state_d = ST_POP;
				else state_d = ST_SCAN_RD;
			end
			ST_AUG_RD_FWD: begin
				// first entry: add bottleneck and start at the sink
				cmd.aug_init = 1'b1;
				state_d = ST_AUG_WR_FWD;
			end
			ST_AUG_WR_FWD: begin
				if (stat.aug_at_src) begin
					state_d = ST_BFS_INIT;
				end else begin
					cmd.aug_rd_fwd = 1'b1;
					state_d = ST_AUG_WR_REV;
				end
			end
			ST_AUG_WR_REV: begin
				cmd.aug_wr_fwd = 1'b1;
				state_d = ST_AUG_ADV;
			end
			ST_AUG_ADV: begin
				// reverse write lands here and the path cursor steps to the parent
				state_d = ST_AUG_WR_FWD;
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == ST_IDLE) else $error("accept while busy");
	a_compute_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_action == ACT_COMPUTE) |=> state_q == ST_COPY)
		else $error("compute not started");
	a_ready_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready during result");
`endif

endmodule

@@ rtl/core/mfek_rev.sv @@
// Reverse update stage: sequences residual read-modify-write for one path edge.
module mfek_rev (
	input  logic           clk,
	input  logic           arst_n,
	input  mfek_pkg::cmd_t cmd_in,
	output mfek_pkg::cmd_t cmd_out
);
	import mfek_pkg::*;

	logic rev_q;

	// Register the forward write so it becomes a reverse write in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rev_q <= 1'b0;
		else         rev_q <= cmd_in.aug_wr_fwd;
	end

	always_comb begin
		cmd_out = cmd_in;
		cmd_out.aug_wr_rev = rev_q;
	end

endmodule

@@ rtl/core/max_flow_edmonds_karp_top.sv @@
// Top level: Edmonds-Karp max-flow engine with stream and APB ports.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata[0]=action,[4:1]=from,[8:5]=to,[24:9]=cap
//  m_axis   | out       | tdata[19:0]=total_flow
//  apb      | in        | 0x0 source_node, 0x4 sink_node
//
// After reset a clearing pass zeroes all 256 cells of the capacity memory.
// A compute item copies 256 residual cells, then each search scans every node
// for each popped node, and each augmenting edge reads and writes its forward
// residual cell and then writes its reverse cell.
// The result holds on m_axis until taken; no item is accepted meanwhile.
module max_flow_edmonds_karp_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // action, from_node, to_node, edge_capacity
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // total_flow
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mfek_pkg::*;

	logic [NODE_W-1:0] src_q, dst_q;
	cmd_t  cmd_c, cmd;
	stat_t stat;
	logic  in_fire, in_ready;
	logic [FLOW_W-1:0] flow;

	// Configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= '0;
			dst_q <= NODE_W'(15);
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && !paddr[2]) begin
			src_q <= pwdata[NODE_W-1:0];
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2]) begin
			dst_q <= pwdata[NODE_W-1:0];
		end
	end
	assign prdata = paddr[2] ? {28'd0, dst_q} : {28'd0, src_q};

	assign s_axis_tready = in_ready;
	assign in_fire = s_axis_tvalid && in_ready;

	mfek_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(in_fire), .in_action(s_axis_tdata[0]),
		.in_edge_ok(1'b1), .out_ready(m_axis_tready),
		.bad_cfg(src_q == dst_q), .stat(stat), .cmd(cmd_c),
		.in_ready(in_ready), .out_valid(m_axis_tvalid)
	);

	mfek_rev u_rev (.clk(clk), .arst_n(arst_n), .cmd_in(cmd_c), .cmd_out(cmd));

	mfek_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.src(src_q), .dst(dst_q),
		.ld_from(s_axis_tdata[4:1]), .ld_to(s_axis_tdata[8:5]),
		.ld_cap(s_axis_tdata[24:9]), .flow(flow)
	);

	assign m_axis_tdata = {4'd0, flow};

endmodule
